@@ rtl/qrm_pkg.sv @@
// ============================================================================
// qrm_pkg
// Shared types and constants for the qubit register measurement block.
// ============================================================================
package qrm_pkg;

   localparam logic [2:0] OP_RESET   = 3'd0;
   localparam logic [2:0] OP_LOAD    = 3'd1;
   localparam logic [2:0] OP_READ    = 3'd2;
   localparam logic [2:0] OP_MEAS    = 3'd3;
   localparam logic [2:0] OP_MEAS_Q  = 3'd4;

   localparam logic [15:0] AMP_ONE   = 16'd16384;  // 1.0 in Q2.14
   localparam int          RTHR_SHIFT = 12;        // random value to Q4.28
   localparam int          FRAC_BITS  = 14;
   localparam int          DIV_STEPS  = 16;        // quotient bits per part

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_READ_DATA,
      ST_SCAN,
      ST_SQRT,
      ST_SC_ISSUE,
      ST_SC_LOAD,
      ST_SC_DIV,
      ST_SC_WRITE,
      ST_DONE
   } state_type;

endpackage

@@ rtl/qrm_if.sv @@
// ============================================================================
// qrm_if
// Request and response channel interfaces for the qubit register block.
// ============================================================================
interface qrm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [9:0]  basis_index;
   logic signed [15:0] load_real;
   logic signed [15:0] load_imag;
   logic [3:0]  target_qubit;
   logic [15:0] random_value;

   modport source (output valid, op, basis_index, load_real, load_imag,
                   target_qubit, random_value, input ready);
   modport sink   (input valid, op, basis_index, load_real, load_imag,
                   target_qubit, random_value, output ready);
endinterface

interface qrm_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  outcome;
   logic signed [15:0] read_real;
   logic signed [15:0] read_imag;
   logic        status;

   modport source (output valid, outcome, read_real, read_imag, status,
                   input ready);
   modport sink   (input valid, outcome, read_real, read_imag, status,
                   output ready);
endinterface

@@ rtl/qubit_register_measure_top.sv @@
// ============================================================================
// qubit_register_measure_top
// State vector of 2^QUBITS complex Q2.14 amplitudes with load, read and
// projective measurement of the whole register or of one qubit.
// ============================================================================
// One request is worked at a time; the result sits in an output register so
// the next request is taken while it waits. After reset, and for a ground
// state reset request, a clearing pass writes all 2^QUBITS entries, one per
// cycle, before requests are taken. A load writes its entry in one state; a
// read addresses the memory, then captures the registered data. Measuring the
// register streams the amplitude memory once through a three stage
// probability/accumulate pipeline. Measuring a qubit takes that scan, then a
// bit-serial square root, then a pass where each entry on the discarded side
// is zeroed from the issue state and each surviving entry is read, divided by
// two parallel 16-step dividers and written back; a zero norm skips the
// dividers for every entry.
module qubit_register_measure_top
   import qrm_pkg::*;
#(
   parameter int QUBITS = 10
) (
   input  logic      clock,
   input  logic      reset,
   qrm_req_if.sink   req_chan,
   qrm_rsp_if.source rsp_chan
);

   localparam int AW    = QUBITS;
   localparam int DEPTH = 1 << QUBITS;
   localparam int SUMW  = QUBITS + 32;
   localparam int SQW   = SUMW + (SUMW % 2);
   localparam int NW    = SQW / 2;
   localparam int NUMW  = 31;

   function automatic logic tbit(input logic [AW-1:0] i, input logic [3:0] t);
      logic [AW-1:0] s;
      s = i >> t;
      return (32'(t) < QUBITS) ? s[0] : 1'b0;
   endfunction

   state_type state_ff, state_in;

   // latched request
   logic [2:0]  op_ff;
   logic [9:0]  idx_ff;
   logic [15:0] lre_ff, lim_ff;
   logic [3:0]  tgt_ff;
   logic [15:0] rv_ff;

   // memory
   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;
   logic [AW-1:0] raddr, waddr;
   logic [31:0] wdata;
   logic        we;

   logic [AW:0] clr_ff;
   logic        clr_rsp_ff;

   // scan pipeline
   logic [AW:0]   scan_ff;
   logic          rd_valid_ff, p_valid_ff;
   logic [AW-1:0] rd_idx_ff, p_idx_ff;
   logic [31:0]   prob_ff;
   logic          p_match_ff;
   logic [SUMW-1:0] sum_ff, p0_ff, sum_in;
   logic          found_ff;
   logic [AW-1:0] hit_ff;
   logic          scan_done;
   logic [SUMW-1:0] rthr;

   // square root
   logic [SQW-1:0] sq_rem_ff, sq_res_ff, sq_bit_ff, sq_try;
   logic           bit_ff;
   logic [NW-1:0]  norm;
   logic           norm_zero;

   // scaling pass
   logic [AW:0]    sc_ff;
   logic [AW-1:0]  sc_idx;
   logic           sc_mism;
   logic [3:0]     div_cnt_ff;
   logic [NW-1:0]  dv_rem_ff [2];
   logic [15:0]    dv_num_ff [2];
   logic           dv_ovf_ff [2];
   logic           dv_neg_ff [2];
   logic [NW-1:0]  ld_rem [2], it_rem [2];
   logic [15:0]    ld_num [2], it_num [2], sat [2];
   logic           ld_ovf [2], ld_neg [2];

   // results
   logic [9:0]  res_out_ff;
   logic [15:0] res_re_ff, res_im_ff;
   logic        res_st_ff;
   logic        rsp_valid_ff;
   logic [9:0]  rsp_out_ff;
   logic [15:0] rsp_re_ff, rsp_im_ff;
   logic        rsp_st_ff;
   logic        out_free;
   logic        accept;
   logic        idx_ok;

   assign accept    = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign idx_ok    = 32'(idx_ff) < DEPTH;
   assign rthr      = SUMW'({rv_ff, {RTHR_SHIFT{1'b0}}});
   assign scan_done = scan_ff[AW] && !rd_valid_ff && !p_valid_ff;
   assign norm      = sq_res_ff[NW-1:0];
   assign norm_zero = (norm == '0);
   assign sc_idx    = sc_ff[AW-1:0];
   assign sc_mism   = tbit(sc_idx, tgt_ff) != bit_ff;
   assign sum_in    = sum_ff + SUMW'(prob_ff);
   assign sq_try    = sq_res_ff + sq_bit_ff;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff[AW]) state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.op)
                  OP_RESET:  state_in = ST_CLEAR;
                  OP_LOAD:   state_in = ST_WRITE;
                  OP_READ:   state_in = ST_READ;
                  OP_MEAS:   state_in = ST_SCAN;
                  OP_MEAS_Q: state_in = ST_SCAN;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_WRITE:     state_in = ST_DONE;
         ST_READ:      state_in = ST_READ_DATA;
         ST_READ_DATA: state_in = ST_DONE;
         ST_SCAN:      if (scan_done) state_in = (op_ff == OP_MEAS) ? ST_DONE : ST_SQRT;
         ST_SQRT:      if (sq_bit_ff[0]) state_in = ST_SC_ISSUE;
         ST_SC_ISSUE: begin
            if (sc_ff[AW]) state_in = ST_DONE;
            else if (!sc_mism && !norm_zero) state_in = ST_SC_LOAD;
         end
         ST_SC_LOAD:   state_in = ST_SC_DIV;
         ST_SC_DIV:    if (div_cnt_ff == 4'(DIV_STEPS - 1)) state_in = ST_SC_WRITE;
         ST_SC_WRITE:  state_in = ST_SC_ISSUE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs / memory control ----------------
   always_comb begin
      req_chan.ready = 1'b0;
      we    = 1'b0;
      waddr = sc_idx;
      wdata = '0;
      raddr = scan_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: req_chan.ready = 1'b1;
         ST_CLEAR: begin
            we    = !clr_ff[AW];
            waddr = clr_ff[AW-1:0];
            wdata = (clr_ff == '0) ? {16'd0, AMP_ONE} : 32'd0;
         end
         ST_WRITE: begin
            we    = idx_ok;
            waddr = AW'(idx_ff);
            wdata = {lim_ff, lre_ff};
         end
         ST_READ:     raddr = AW'(idx_ff);
         ST_SC_ISSUE: begin
            raddr = sc_idx;
            we    = !sc_ff[AW] && sc_mism;
         end
         ST_SC_WRITE: begin
            we    = 1'b1;
            wdata = {sat[1], sat[0]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // ---------------- divider lanes ----------------
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         logic [15:0]     part, mag;
         logic [NUMW-1:0] n_full;
         logic [NW:0]     t;
         logic            ge;
         part      = rdata_ff[16*l +: 16];
         ld_neg[l] = part[15];
         mag       = part[15] ? 16'(-part) : part;
         n_full    = NUMW'({mag, {FRAC_BITS{1'b0}}}) + NUMW'(norm >> 1);
         ld_ovf[l] = NW'(n_full[NUMW-1:16]) >= norm;
         ld_rem[l] = NW'(n_full[NUMW-1:16]);
         ld_num[l] = n_full[15:0];
         t         = {dv_rem_ff[l], dv_num_ff[l][15]};
         ge        = t >= {1'b0, norm};
         it_rem[l] = ge ? NW'(t - {1'b0, norm}) : t[NW-1:0];
         it_num[l] = {dv_num_ff[l][14:0], ge};
         if (dv_neg_ff[l])
            sat[l] = (dv_ovf_ff[l] || dv_num_ff[l] > 16'd32768) ? 16'h8000
                                                                 : 16'(-dv_num_ff[l]);
         else
            sat[l] = (dv_ovf_ff[l] || dv_num_ff[l][15]) ? 16'h7fff : dv_num_ff[l];
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         p_valid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == ST_SCAN) && !scan_ff[AW];
         p_valid_ff  <= rd_valid_ff;
         if (state_ff == ST_CLEAR && !clr_ff[AW]) clr_ff <= clr_ff + 1'b1;
         if (accept && req_chan.op == OP_RESET) begin
            clr_ff     <= '0;
            clr_rsp_ff <= 1'b1;
         end
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_chan.op;
         idx_ff     <= req_chan.basis_index;
         lre_ff     <= req_chan.load_real;
         lim_ff     <= req_chan.load_imag;
         tgt_ff     <= req_chan.target_qubit;
         rv_ff      <= req_chan.random_value;
         res_out_ff <= '0;
         res_re_ff  <= '0;
         res_im_ff  <= '0;
         res_st_ff  <= 1'b0;
         scan_ff    <= '0;
         sum_ff     <= '0;
         p0_ff      <= '0;
         found_ff   <= 1'b0;
         sc_ff      <= '0;
      end

      // scan: read, probability, accumulate
      if (state_ff == ST_SCAN && !scan_ff[AW]) scan_ff <= scan_ff + 1'b1;
      rd_idx_ff  <= scan_ff[AW-1:0];
      p_idx_ff   <= rd_idx_ff;
      p_match_ff <= !tbit(rd_idx_ff, tgt_ff);
      prob_ff    <= $unsigned(32'($signed(rdata_ff[15:0]) * $signed(rdata_ff[15:0])))
                  + $unsigned(32'($signed(rdata_ff[31:16]) * $signed(rdata_ff[31:16])));
      if (state_ff == ST_SCAN && p_valid_ff) begin
         sum_ff <= sum_in;
         if (p_match_ff) p0_ff <= p0_ff + SUMW'(prob_ff);
         if (!found_ff && rthr < sum_in) begin
            found_ff <= 1'b1;
            hit_ff   <= p_idx_ff;
         end
      end

      if (state_ff == ST_SCAN && scan_done) begin
         res_out_ff <= found_ff ? 10'(hit_ff) : 10'(DEPTH - 1);
         bit_ff     <= !(rthr < p0_ff);
         sq_rem_ff  <= SQW'((rthr < p0_ff) ? p0_ff : sum_ff - p0_ff);
         sq_res_ff  <= '0;
         sq_bit_ff  <= SQW'(1) << (SQW - 2);
      end

      if (state_ff == ST_SQRT) begin
         if (sq_rem_ff >= sq_try) begin
            sq_rem_ff <= sq_rem_ff - sq_try;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
         if (sq_bit_ff[0]) begin
            res_out_ff <= 10'(bit_ff);
            res_st_ff  <= ((sq_rem_ff >= sq_try) ? (sq_res_ff >> 1) + sq_bit_ff
                                                 : sq_res_ff >> 1) == '0;
         end
      end

      if (state_ff == ST_SC_ISSUE && !sc_ff[AW] && (sc_mism || norm_zero))
         sc_ff <= sc_ff + 1'b1;
      if (state_ff == ST_SC_WRITE) sc_ff <= sc_ff + 1'b1;

      if (state_ff == ST_SC_LOAD) begin
         div_cnt_ff <= '0;
         for (int l = 0; l < 2; l++) begin
            dv_rem_ff[l] <= ld_rem[l];
            dv_num_ff[l] <= ld_num[l];
            dv_ovf_ff[l] <= ld_ovf[l];
            dv_neg_ff[l] <= ld_neg[l];
         end
      end
      if (state_ff == ST_SC_DIV) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         for (int l = 0; l < 2; l++) begin
            if (!dv_ovf_ff[l]) begin
               dv_rem_ff[l] <= it_rem[l];
               dv_num_ff[l] <= it_num[l];
            end
         end
      end

      if (state_ff == ST_READ_DATA && idx_ok) begin
         res_re_ff <= rdata_ff[15:0];
         res_im_ff <= rdata_ff[31:16];
      end

      if (state_ff == ST_DONE && out_free) begin
         rsp_out_ff <= res_out_ff;
         rsp_re_ff  <= res_re_ff;
         rsp_im_ff  <= res_im_ff;
         rsp_st_ff  <= res_st_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.outcome   = rsp_out_ff;
   assign rsp_chan.read_real = rsp_re_ff;
   assign rsp_chan.read_imag = rsp_im_ff;
   assign rsp_chan.status    = rsp_st_ff;

endmodule

@@ rtl/qrm_checker.sv @@
// ============================================================================
// qrm_assert_checker
// Port-level checks for the qubit register measurement block.
// ============================================================================
module qrm_assert_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [9:0]  outcome,
   input logic [15:0] read_real,
   input logic [15:0] read_imag,
   input logic        status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(outcome) && $stable(status))
      else $error("response changed while stalled");

   // clearing pass follows reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken back to back");

   // zero norm only comes from a qubit measurement
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status |-> outcome[9:1] == '0 && read_real == '0 &&
                               read_imag == '0)
      else $error("zero norm flag on a non qubit result");

endmodule

bind qubit_register_measure_top qrm_assert_checker u_qrm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .outcome   (rsp_chan.outcome),
   .read_real (rsp_chan.read_real),
   .read_imag (rsp_chan.read_imag),
   .status    (rsp_chan.status)
);
